// ===== design/jst_pkg.sv =====
// Shared types, constants and helpers for the JSON structure tokenizer.
// Used by jst_ctrl, jst_cell and json_structure_tokenizer_top; depends on nothing.

package jst_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int BYTE_W      = 8;
    localparam int EVENT_W     = 4;
    localparam int LEVEL_W     = 6;
    localparam int MAX_PUSH    = 4;
    localparam int NB_BACK     = 4;
    localparam int NB_CNT      = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [2:0] {
        EXP_KEY    = 3'd0,
        EXP_COLON  = 3'd1,
        EXP_DATA   = 3'd2,
        EXP_OBJEND = 3'd3,
        EXP_ARREND = 3'd4,
        EXP_STR    = 3'd5,
        EXP_VAL    = 3'd6,
        EXP_NONE   = 3'd7
    } exp_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_WAIT      = 4'd0,
        EV_ERR       = 4'd1,
        EV_OBJ_START = 4'd2,
        EV_OBJ_DONE  = 4'd3,
        EV_ARR_START = 4'd4,
        EV_ARR_DONE  = 4'd5,
        EV_KEY_START = 4'd6,
        EV_KEY_END   = 4'd7,
        EV_STR_START = 4'd8,
        EV_STR_END   = 4'd9,
        EV_VAL_START = 4'd10
    } event_t;

    // Update for one byte: new top entries, shift select for the cell row,
    // new fill level, escape flag and the event to report.
    typedef struct packed {
        exp_t [MAX_PUSH-1:0] ins;
        logic [2:0]          ins_cnt;
        logic [2:0]          sel;
        cnt_t                count_next;
        logic                esc_next;
        event_t              ev;
    } step_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || (c == 8'h0A) || (c == 8'h09) ||
               (c == 8'h0D) || (c == 8'h0C) || (c == 8'h0B);
    endfunction

endpackage

// ===== design/jst_ctrl.sv =====
// Per-byte decoder: looks at the byte, the two top stack cells, the fill level
// and the escape flag, and produces the update for the cell row. Depends on jst_pkg.

module jst_ctrl (
    input  logic [jst_pkg::BYTE_W-1:0] text_byte,
    input  jst_pkg::exp_t              top_entry,
    input  jst_pkg::exp_t              below_entry,
    input  jst_pkg::cnt_t              count,
    input  logic                       esc,
    output jst_pkg::step_t             step
);

    always_comb begin
        jst_pkg::exp_t                        t;
        jst_pkg::exp_t                        b;
        jst_pkg::exp_t [jst_pkg::MAX_PUSH-1:0] pv;
        jst_pkg::exp_t [jst_pkg::MAX_PUSH-1:0] ins;
        jst_pkg::event_t                      ev;
        jst_pkg::cnt_t                        count1;
        jst_pkg::cnt_t                        room;
        logic [1:0]                           pops;
        logic [2:0]                           np;
        logic [2:0]                           p;
        logic [2:0]                           idx;
        logic                                 esc_n;
        logic                                 space;

        t     = (count == '0) ? jst_pkg::EXP_NONE : top_entry;
        b     = (count > jst_pkg::cnt_t'(1)) ? below_entry : jst_pkg::EXP_NONE;
        pops  = 2'd0;
        np    = 3'd0;
        ev    = jst_pkg::EV_WAIT;
        esc_n = esc;
        space = jst_pkg::is_space(text_byte);
        for (int j = 0; j < jst_pkg::MAX_PUSH; j++) begin
            pv[j] = jst_pkg::EXP_NONE;
        end

        // Push lists are written bottom entry first.
        unique case (t)
            jst_pkg::EXP_KEY: begin
                if (text_byte == jst_pkg::CH_QUOTE) begin
                    pops  = 2'd1;
                    pv[0] = jst_pkg::EXP_STR;
                    np    = 3'd1;
                    esc_n = 1'b0;
                    ev    = jst_pkg::EV_KEY_START;
                end else begin
                    ev = space ? jst_pkg::EV_WAIT : jst_pkg::EV_ERR;
                end
            end
            jst_pkg::EXP_COLON: begin
                if (text_byte == jst_pkg::CH_COLON) begin
                    pops = 2'd1;
                end else begin
                    ev = space ? jst_pkg::EV_WAIT : jst_pkg::EV_ERR;
                end
            end
            jst_pkg::EXP_NONE: begin
                if (text_byte == jst_pkg::CH_LBRACE) begin
                    pv[0] = jst_pkg::EXP_OBJEND;
                    pv[1] = jst_pkg::EXP_DATA;
                    pv[2] = jst_pkg::EXP_COLON;
                    pv[3] = jst_pkg::EXP_KEY;
                    np    = 3'd4;
                    ev    = jst_pkg::EV_OBJ_START;
                end else if (text_byte == jst_pkg::CH_LBRACKET) begin
                    pv[0] = jst_pkg::EXP_ARREND;
                    pv[1] = jst_pkg::EXP_DATA;
                    np    = 3'd2;
                    ev    = jst_pkg::EV_ARR_START;
                end else begin
                    ev = space ? jst_pkg::EV_WAIT : jst_pkg::EV_ERR;
                end
            end
            jst_pkg::EXP_DATA: begin
                if (!space) begin
                    pops = 2'd1;
                    if (text_byte == jst_pkg::CH_LBRACE) begin
                        pv[0] = jst_pkg::EXP_OBJEND;
                        pv[1] = jst_pkg::EXP_DATA;
                        pv[2] = jst_pkg::EXP_COLON;
                        pv[3] = jst_pkg::EXP_KEY;
                        np    = 3'd4;
                        ev    = jst_pkg::EV_OBJ_START;
                    end else if (text_byte == jst_pkg::CH_LBRACKET) begin
                        pv[0] = jst_pkg::EXP_ARREND;
                        pv[1] = jst_pkg::EXP_DATA;
                        np    = 3'd2;
                        ev    = jst_pkg::EV_ARR_START;
                    end else if (text_byte == jst_pkg::CH_QUOTE) begin
                        pv[0] = jst_pkg::EXP_STR;
                        np    = 3'd1;
                        esc_n = 1'b0;
                        ev    = jst_pkg::EV_STR_START;
                    end else begin
                        pv[0] = jst_pkg::EXP_VAL;
                        np    = 3'd1;
                        ev    = jst_pkg::EV_VAL_START;
                    end
                end
            end
            jst_pkg::EXP_OBJEND: begin
                if (text_byte == jst_pkg::CH_RBRACE) begin
                    pops = 2'd1;
                    ev   = jst_pkg::EV_OBJ_DONE;
                end else if (text_byte == jst_pkg::CH_COMMA) begin
                    pv[0] = jst_pkg::EXP_DATA;
                    pv[1] = jst_pkg::EXP_COLON;
                    pv[2] = jst_pkg::EXP_KEY;
                    np    = 3'd3;
                end else begin
                    ev = space ? jst_pkg::EV_WAIT : jst_pkg::EV_ERR;
                end
            end
            jst_pkg::EXP_ARREND: begin
                if (text_byte == jst_pkg::CH_RBRACKET) begin
                    pops = 2'd1;
                    ev   = jst_pkg::EV_ARR_DONE;
                end else if (text_byte == jst_pkg::CH_COMMA) begin
                    pv[0] = jst_pkg::EXP_DATA;
                    np    = 3'd1;
                end else begin
                    ev = space ? jst_pkg::EV_WAIT : jst_pkg::EV_ERR;
                end
            end
            jst_pkg::EXP_STR: begin
                if (esc) begin
                    esc_n = 1'b0;
                end else if (text_byte == jst_pkg::CH_BACKSLASH) begin
                    esc_n = 1'b1;
                end else if (text_byte == jst_pkg::CH_QUOTE) begin
                    pops = 2'd1;
                    ev   = (b == jst_pkg::EXP_COLON) ? jst_pkg::EV_KEY_END
                                                     : jst_pkg::EV_STR_END;
                end
            end
            jst_pkg::EXP_VAL: begin
                // A delimiter closes the bare value and is then handled again by
                // the entry below it, all in the same cycle.
                if (text_byte == jst_pkg::CH_RBRACE) begin
                    if (b == jst_pkg::EXP_OBJEND) begin
                        pops = 2'd2;
                        ev   = jst_pkg::EV_OBJ_DONE;
                    end else begin
                        ev = jst_pkg::EV_ERR;
                    end
                end else if (text_byte == jst_pkg::CH_RBRACKET) begin
                    if (b == jst_pkg::EXP_ARREND) begin
                        pops = 2'd2;
                        ev   = jst_pkg::EV_ARR_DONE;
                    end else begin
                        ev = jst_pkg::EV_ERR;
                    end
                end else if (text_byte == jst_pkg::CH_COMMA) begin
                    if (b == jst_pkg::EXP_OBJEND) begin
                        pops  = 2'd1;
                        pv[0] = jst_pkg::EXP_DATA;
                        pv[1] = jst_pkg::EXP_COLON;
                        pv[2] = jst_pkg::EXP_KEY;
                        np    = 3'd3;
                    end else if (b == jst_pkg::EXP_ARREND) begin
                        pops  = 2'd1;
                        pv[0] = jst_pkg::EXP_DATA;
                        np    = 3'd1;
                    end else begin
                        ev = jst_pkg::EV_ERR;
                    end
                end
            end
        endcase

        // Pushes that do not fit are dropped; those that fit stay and the byte
        // reports an error.
        count1 = count - jst_pkg::cnt_t'(pops);
        room   = jst_pkg::cnt_t'(jst_pkg::STACK_DEPTH) - count1;
        if (jst_pkg::cnt_t'(np) > room) begin
            p = 3'(room);
        end else begin
            p = np;
        end
        if (p != np) begin
            ev = jst_pkg::EV_ERR;
        end

        // New cell j (top is cell 0) takes push number p-1-j.
        for (int j = 0; j < jst_pkg::MAX_PUSH; j++) begin
            idx    = p - 3'(j) - 3'd1;
            ins[j] = (3'(j) < p) ? pv[idx[1:0]] : jst_pkg::EXP_NONE;
        end

        step.ins        = ins;
        step.ins_cnt    = p;
        step.sel        = 3'(jst_pkg::NB_BACK) + {1'b0, pops} - p;
        step.count_next = count1 + jst_pkg::cnt_t'(p);
        step.esc_next   = esc_n;
        step.ev         = ev;
    end

endmodule

// ===== design/jst_cell.sv =====
// One stack cell of the tokenizer: holds one expectation entry and each step takes
// either a freshly pushed entry or the entry of a nearby cell. Depends on jst_pkg.

module jst_cell (
    input  logic                                 aclk,
    input  logic                                 step_en,
    input  logic                                 load_en,
    input  jst_pkg::exp_t                        load_val,
    input  jst_pkg::exp_t [jst_pkg::NB_CNT-1:0]  nb,
    input  logic [2:0]                           sel,
    output jst_pkg::exp_t                        entry
);

    jst_pkg::exp_t entry_reg;
    jst_pkg::exp_t entry_next;

    always_comb begin
        if (load_en) begin
            entry_next = load_val;
        end else if (sel < 3'(jst_pkg::NB_CNT)) begin
            entry_next = nb[sel];
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== design/json_structure_tokenizer_top.sv =====
// Top level of the streaming JSON structure tokenizer.
// Depends on jst_pkg, jst_ctrl and jst_cell.

// The block reads JSON text one byte per transaction on the slave stream (s_*)
// and returns exactly one event transaction per byte on the master stream (m_*).
// Each event carries the event code and the stack depth after that byte.
// The expectation stack is a row of cells with the top in cell 0; every byte
// shifts the row by up to two places toward the top (pops) or up to four places
// away from it (pushes), so each cell only ever looks at its close neighbors.
// A bare value closed by a delimiter is popped and the delimiter is handled by
// the entry below in the same cycle. The event of a byte accepted at one edge is
// registered and valid on m_tvalid/m_tdata right after that edge. Throughput is
// one byte per cycle while the receiver keeps up, limited by the update of the
// stack row and its fill level.
// The event sits in an output register; a new byte is accepted whenever that
// register is empty or is being taken in the same cycle. When the receiver
// stalls, s_tready drops and the pending event is held unchanged.
// A synchronous active-low reset empties the stack, clears the escape flag and
// the output valid flag, and holds s_tready low while it is asserted. Cell contents
// are not reset; cells above the fill level are never consulted. Errors are not
// sticky: decoding goes on with the next byte.

module json_structure_tokenizer_top (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [jst_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] text_byte

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [jst_pkg::M_TDATA_W-1:0] m_tdata    // [3:0] event_code, [9:4] level_count
);

    localparam int PAD_W = jst_pkg::M_TDATA_W - jst_pkg::EVENT_W - jst_pkg::LEVEL_W;

    logic                             step_en;
    jst_pkg::step_t                   step;
    jst_pkg::exp_t [jst_pkg::STACK_DEPTH-1:0] cell_val;

    jst_pkg::cnt_t                    count_reg;
    logic                             esc_reg;
    logic                             m_tvalid_reg;
    logic [jst_pkg::M_TDATA_W-1:0]    m_tdata_reg;
    logic [jst_pkg::M_TDATA_W-1:0]    m_tdata_next;

    // A byte transaction completes when the output register is free or drains now.
    // No byte is taken while reset is asserted.
    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);
    assign step_en  = s_tvalid && s_tready;

    jst_ctrl u_ctrl (
        .text_byte   (s_tdata[jst_pkg::BYTE_W-1:0]),
        .top_entry   (cell_val[0]),
        .below_entry (cell_val[1]),
        .count       (count_reg),
        .esc         (esc_reg),
        .step        (step)
    );

    // The cell row. Neighbor k of cell j is cell j+k-NB_BACK; positions off the
    // row read as empty and land above the new fill level or are replaced by a push.
    for (genvar j = 0; j < jst_pkg::STACK_DEPTH; j++) begin : g_cell
        jst_pkg::exp_t [jst_pkg::NB_CNT-1:0] nb;
        logic                                load_en;
        jst_pkg::exp_t                       load_val;

        for (genvar k = 0; k < jst_pkg::NB_CNT; k++) begin : g_nb
            if ((j + k - jst_pkg::NB_BACK < 0) ||
                (j + k - jst_pkg::NB_BACK >= jst_pkg::STACK_DEPTH)) begin : g_off
                assign nb[k] = jst_pkg::EXP_NONE;
            end else begin : g_on
                assign nb[k] = cell_val[j + k - jst_pkg::NB_BACK];
            end
        end

        if (j < jst_pkg::MAX_PUSH) begin : g_load
            assign load_en  = (3'(j) < step.ins_cnt);
            assign load_val = step.ins[j];
        end else begin : g_noload
            assign load_en  = 1'b0;
            assign load_val = jst_pkg::EXP_NONE;
        end

        jst_cell u_cell (
            .aclk     (aclk),
            .step_en  (step_en),
            .load_en  (load_en),
            .load_val (load_val),
            .nb       (nb),
            .sel      (step.sel),
            .entry    (cell_val[j])
        );
    end

    assign m_tdata_next = {{PAD_W{1'b0}},
                           jst_pkg::LEVEL_W'(step.count_next),
                           step.ev};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            esc_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (step_en) begin
                count_reg    <= step.count_next;
                esc_reg      <= step.esc_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/jst_tb_pkg.sv =====
// Scoreboard for the JSON structure tokenizer testbench: a bit-accurate predictor of
// the expectation stack and a queue of expected event transactions.
// Depends on jst_pkg for widths, character codes and the state and event enums.

package jst_tb_pkg;

    import jst_pkg::*;

    typedef struct packed {
        event_t             code;
        logic [LEVEL_W-1:0] level;
    } token_t;

    class token_scoreboard;
        exp_t   row [STACK_DEPTH];
        int     fill;
        bit     in_escape;
        bit     rehandle;
        token_t awaited [$];
        int     fail_count;

        function new();
            fill       = 0;
            in_escape  = 1'b0;
            rehandle   = 1'b0;
            fail_count = 0;
        endfunction

        static function bit is_blank(logic [BYTE_W-1:0] c);
            return c inside {8'h20, 8'h0A, 8'h09, 8'h0D, 8'h0C, 8'h0B};
        endfunction

        // Entry d places below the top, or EXP_NONE when the stack is shallower.
        function exp_t top_at(int d);
            if (d >= fill) return EXP_NONE;
            return row[fill - 1 - d];
        endfunction

        function bit push_entry(exp_t s);
            if (fill >= STACK_DEPTH) return 1'b0;
            row[fill] = s;
            fill++;
            return 1'b1;
        endfunction

        function void pop_entry();
            if (fill > 0) fill--;
        endfunction

        // Pushes stop at the first one that fails; earlier ones stay.
        function bit open_object();
            if (!push_entry(EXP_OBJEND)) return 1'b0;
            if (!push_entry(EXP_DATA)) return 1'b0;
            if (!push_entry(EXP_COLON)) return 1'b0;
            return push_entry(EXP_KEY);
        endfunction

        function bit open_array();
            if (!push_entry(EXP_ARREND)) return 1'b0;
            return push_entry(EXP_DATA);
        endfunction

        // One pass of a byte against the current top. Sets rehandle when a bare value
        // was popped and the same byte must be seen again.
        function event_t handle(logic [BYTE_W-1:0] c);
            exp_t below;
            rehandle = 1'b0;
            case (top_at(0))
                EXP_KEY: begin
                    if (c == CH_QUOTE) begin
                        pop_entry();
                        if (!push_entry(EXP_STR)) return EV_ERR;
                        in_escape = 1'b0;
                        return EV_KEY_START;
                    end
                    return is_blank(c) ? EV_WAIT : EV_ERR;
                end
                EXP_COLON: begin
                    if (c == CH_COLON) begin
                        pop_entry();
                        return EV_WAIT;
                    end
                    return is_blank(c) ? EV_WAIT : EV_ERR;
                end
                EXP_NONE: begin
                    if (c == CH_LBRACE) return open_object() ? EV_OBJ_START : EV_ERR;
                    if (c == CH_LBRACKET) return open_array() ? EV_ARR_START : EV_ERR;
                    return is_blank(c) ? EV_WAIT : EV_ERR;
                end
                EXP_DATA: begin
                    if (is_blank(c)) return EV_WAIT;
                    pop_entry();
                    if (c == CH_LBRACE) return open_object() ? EV_OBJ_START : EV_ERR;
                    if (c == CH_LBRACKET) return open_array() ? EV_ARR_START : EV_ERR;
                    if (c == CH_QUOTE) begin
                        if (!push_entry(EXP_STR)) return EV_ERR;
                        in_escape = 1'b0;
                        return EV_STR_START;
                    end
                    return push_entry(EXP_VAL) ? EV_VAL_START : EV_ERR;
                end
                EXP_OBJEND: begin
                    if (c == CH_RBRACE) begin
                        pop_entry();
                        return EV_OBJ_DONE;
                    end
                    if (c == CH_COMMA) begin
                        if (!push_entry(EXP_DATA)) return EV_ERR;
                        if (!push_entry(EXP_COLON)) return EV_ERR;
                        return push_entry(EXP_KEY) ? EV_WAIT : EV_ERR;
                    end
                    return is_blank(c) ? EV_WAIT : EV_ERR;
                end
                EXP_ARREND: begin
                    if (c == CH_RBRACKET) begin
                        pop_entry();
                        return EV_ARR_DONE;
                    end
                    if (c == CH_COMMA) return push_entry(EXP_DATA) ? EV_WAIT : EV_ERR;
                    return is_blank(c) ? EV_WAIT : EV_ERR;
                end
                EXP_STR: begin
                    if (in_escape) begin
                        in_escape = 1'b0;
                        return EV_WAIT;
                    end
                    if (c == CH_BACKSLASH) begin
                        in_escape = 1'b1;
                        return EV_WAIT;
                    end
                    if (c == CH_QUOTE) begin
                        pop_entry();
                        return (top_at(0) == EXP_COLON) ? EV_KEY_END : EV_STR_END;
                    end
                    return EV_WAIT;
                end
                EXP_VAL: begin
                    below = top_at(1);
                    if (c == CH_RBRACE) begin
                        if (below != EXP_OBJEND) return EV_ERR;
                        pop_entry();
                        rehandle = 1'b1;
                        return EV_WAIT;
                    end
                    if (c == CH_RBRACKET) begin
                        if (below != EXP_ARREND) return EV_ERR;
                        pop_entry();
                        rehandle = 1'b1;
                        return EV_WAIT;
                    end
                    if (c == CH_COMMA) begin
                        if (below != EXP_OBJEND && below != EXP_ARREND) return EV_ERR;
                        pop_entry();
                        rehandle = 1'b1;
                        return EV_WAIT;
                    end
                    return EV_WAIT;
                end
                default: return EV_ERR;
            endcase
        endfunction

        // Full update for one byte, including the second pass after a bare value.
        function token_t tokenize_byte(logic [BYTE_W-1:0] c);
            token_t t;
            t.code = handle(c);
            if (rehandle) t.code = handle(c);
            if (rehandle) t.code = EV_ERR;
            t.level = LEVEL_W'(fill);
            return t;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] c);
            awaited.push_back(tokenize_byte(c));
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void report(string what);
            fail_count++;
            if (fail_count <= 10) $display("tokenizer mismatch: %s", what);
        endfunction

        function void check_event(logic [M_TDATA_W-1:0] data);
            token_t want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected event transaction, tdata 0x%04h", data));
                return;
            end
            want = awaited.pop_front();
            if (data[EVENT_W-1:0] !== want.code)
                report($sformatf("event_code expected %0d (%s), got %0d",
                                 want.code, want.code.name(), data[EVENT_W-1:0]));
            if (data[EVENT_W +: LEVEL_W] !== want.level)
                report($sformatf("level_count expected %0d, got %0d",
                                 want.level, data[EVENT_W +: LEVEL_W]));
            if (data[M_TDATA_W-1:EVENT_W+LEVEL_W] !== '0)
                report($sformatf("tdata padding expected 0, got 0x%04h", data));
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for json_structure_tokenizer_top: drives JSON text bytes,
// predicts each event transaction and checks it. Depends on jst_pkg and jst_tb_pkg.

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jst_pkg::*;
    import jst_tb_pkg::*;

    // Non-whitespace random bytes to send after the directed opening.
    localparam int RANDOM_ITEMS   = 2000;
    // Cycles the receiver refuses results once, so the block fills up and stalls.
    localparam int HOLD_CYCLES    = 300;
    // Cycles without any transaction on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [7:0] text_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [3:0] event_code, [9:4] level_count

    // The checker sees bytes as the block accepts them. The shadow copy is advanced
    // as bytes are chosen, so the generator always knows the state its next byte meets.
    token_scoreboard sb;
    token_scoreboard shadow;

    // Traffic phase: 0 sender idles lightly and receiver heavily, 1 the reverse,
    // 2 no idling at all (and the one long receiver hold-off).
    int phase        = 0;
    // Nesting depth the generator is steering toward in the current document.
    int goal_level   = 4;
    int quiet_cycles = 0;

    json_structure_tokenizer_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(5))
            0:       return 8'h20;
            1:       return 8'h0A;
            2:       return 8'h09;
            3:       return 8'h0D;
            4:       return 8'h0C;
            default: return 8'h0B;
        endcase
    endfunction

    // Characters of a bare value: digits and lowercase letters.
    function automatic logic [7:0] value_byte();
        if ($urandom_range(1)) return 8'($urandom_range(8'h30, 8'h39));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Chooses the next text byte. Most bytes continue a well-formed document from
    // the state the shadow predictor is in; a few are pure noise. The depth goal
    // sometimes lies beyond the stack size, to drive pushes into a full stack.
    function automatic logic [7:0] pick_byte();
        exp_t top;
        exp_t below;
        int   lvl;
        int   r;
        bit   grow;
        top   = shadow.top_at(0);
        below = shadow.top_at(1);
        lvl   = shadow.fill;
        if (top == EXP_NONE)
            goal_level = ($urandom_range(9) == 0) ? STACK_DEPTH + 4 : $urandom_range(2, 14);
        else if (lvl >= STACK_DEPTH && $urandom_range(15) == 0)
            goal_level = 0;
        grow = (lvl < goal_level);
        r    = $urandom_range(99);
        if (r < 6) return 8'($urandom);
        r = $urandom_range(99);
        case (top)
            EXP_NONE: begin
                if (r < 10) return blank_byte();
                return (r < 55) ? CH_LBRACE : CH_LBRACKET;
            end
            EXP_KEY:   return (r < 12) ? blank_byte() : CH_QUOTE;
            EXP_COLON: return (r < 12) ? blank_byte() : CH_COLON;
            EXP_DATA: begin
                if (r < 8) return blank_byte();
                if (grow ? (r < 60) : (r < 18))
                    return $urandom_range(1) ? CH_LBRACE : CH_LBRACKET;
                if (r < 65) return CH_QUOTE;
                return value_byte();
            end
            EXP_OBJEND: begin
                if (r < 8) return blank_byte();
                return (grow ? (r < 80) : (r < 30)) ? CH_COMMA : CH_RBRACE;
            end
            EXP_ARREND: begin
                if (r < 8) return blank_byte();
                return (grow ? (r < 80) : (r < 30)) ? CH_COMMA : CH_RBRACKET;
            end
            EXP_STR: begin
                if (r < 10) return CH_BACKSLASH;
                if (r < 35) return CH_QUOTE;
                return 8'($urandom);
            end
            default: begin
                // Inside a bare value: more value text, a blank, or the delimiter that ends it.
                if (r < 10) return blank_byte();
                if (r < 50) return value_byte();
                if (r < 70) return CH_COMMA;
                if (below == EXP_ARREND) return CH_RBRACKET;
                if (below == EXP_OBJEND) return CH_RBRACE;
                return $urandom_range(1) ? CH_RBRACE : CH_RBRACKET;
            end
        endcase
    endfunction

    // Offers one byte after a random number of idle cycles and returns at the
    // rising edge where the transaction is accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap_pct;
        gap_pct = (phase == 0) ? 32 : (phase == 1) ? 56 : 0;
        void'(shadow.tokenize_byte(b));
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Receiver. When the last phase begins it refuses results for a long stretch while
    // the sender keeps offering bytes; otherwise it stalls at random per phase.
    initial begin : receiver
        int  stall_pct;
        bit  held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (phase == 2 && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            stall_pct = (phase == 0) ? 56 : (phase == 1) ? 32 : 0;
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor. Values are sampled at the edge before the nonblocking updates land, so
    // both handshakes are seen exactly as the block saw them. Inputs are noted before
    // results are checked, which keeps the order right for any latency.
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata);
            if (m_tvalid && m_tready) sb.check_event(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // A hung block ends the run here.
    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] lead [5] = '{8'h00, 8'hFF, 8'h78, 8'h0B, 8'h0C};
        string      opening;
        logic [7:0] b;
        int         real_count;
        sb      = new();
        shadow  = new();
        // An object holding an escaped key, an array with a bare value and an empty
        // string, a second key with a bare value closed by the brace, and then an
        // object closed right after it opens, which is a bad character for a key.
        opening = "{\"\\\"\":[7,\"\"],\"\":x}{}";
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Bytes on an empty stack: both extremes, a letter and two kinds of whitespace.
        foreach (lead[i]) send_byte(lead[i]);
        for (int i = 0; i < opening.len(); i++) send_byte(opening[i]);

        real_count = 0;
        while (real_count < RANDOM_ITEMS) begin
            phase = (real_count * 3) / RANDOM_ITEMS;
            b     = pick_byte();
            send_byte(b);
            if (!token_scoreboard::is_blank(b)) real_count++;
        end
        s_tvalid <= 1'b0;

        // A clock edge lets the monitor note the last byte before the queue is polled.
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
